### rtl/core/ecpa_pkg.sv
// Shared types, codes and field arithmetic helpers for the affine point adder.
package ecpa_pkg;

  localparam int FIELD_W = 64;
  localparam int CNT_W = $clog2(FIELD_W);
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A = CFG_IDX_W'(1);

  typedef logic [FIELD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef enum logic [3:0] {
    OPND_ONE,
    OPND_PX,
    OPND_PY,
    OPND_QX,
    OPND_QY,
    OPND_CA,
    OPND_T0,
    OPND_T1,
    OPND_T2
  } opnd_t;

  typedef enum logic [1:0] {
    RES_POINT_P,
    RES_SUM,
    RES_INF
  } res_kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RPX,
    S_RPY,
    S_RQX,
    S_RQY,
    S_RA,
    S_CHK,
    S_XD,
    S_YD,
    S_BR,
    S_SQ,
    S_D2,
    S_D3,
    S_D4,
    S_D5,
    S_IV1,
    S_IVS,
    S_IVM,
    S_SLP,
    S_X1,
    S_X2,
    S_X3,
    S_Y1,
    S_Y2,
    S_Y3,
    S_OUT_P,
    S_OUT_R,
    S_OUT_INF
  } state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    alu_req_t  alu;
    opnd_t     a_sel;
    opnd_t     b_sel;
    opnd_t     dst;
    logic      out_load;
    res_kind_t out_kind;
    logic      in_ready;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_accept;
    logic alu_done;
    logic m_zero;
    logic q_inf;
    logic t0_zero;
    logic t1_zero;
    logic py_zero;
    logic out_free;
  } ctrl_stat_t;

  function automatic word_t fadd(input word_t x, input word_t y, input word_t m);
    logic [FIELD_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[FIELD_W-1:0];
  endfunction

  function automatic word_t fsub(input word_t x, input word_t y, input word_t m);
    word_t d;
    if (x >= y) d = x - y;
    else d = x + (m - y);
    return d;
  endfunction

endpackage

### rtl/core/ec_affine_point_add.sv
// Top level of the affine point adder: configuration, working registers and result register.
// The adder takes one item at a time; the input is stalled until the result is loaded.
// All steps share the single arithmetic unit, whose modular multiply is bit-serial.
// Reset clears the modulus and coefficient registers, the sequencer and the result valid.
module ec_affine_point_add
  import ecpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  word_t                in_p_x,
  input  word_t                in_p_y,
  input  word_t                in_q_x,
  input  word_t                in_q_y,
  input  logic                 in_q_is_infinity,
  output logic                 out_valid,
  input  logic                 out_stall,
  output word_t                out_r_x,
  output word_t                out_r_y,
  output logic                 out_r_is_infinity,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_data
);

  word_t      modulus_r, coeff_a_r;
  word_t      px_r, py_r, qx_r, qy_r, ca_r, t0_r, t1_r, t2_r;
  logic       qinf_r;
  logic       out_valid_r;
  word_t      rx_r, ry_r;
  logic       rinf_r;
  word_t      opa, opb, alu_res;
  logic       alu_done;
  logic       in_acc;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  function automatic word_t pick(input opnd_t s, input word_t px, input word_t py,
                                 input word_t qx, input word_t qy, input word_t ca,
                                 input word_t t0, input word_t t1, input word_t t2);
    word_t v;
    unique case (s)
      OPND_PX: v = px;
      OPND_PY: v = py;
      OPND_QX: v = qx;
      OPND_QY: v = qy;
      OPND_CA: v = ca;
      OPND_T0: v = t0;
      OPND_T1: v = t1;
      OPND_T2: v = t2;
      default: v = word_t'(1);
    endcase
    return v;
  endfunction

  assign in_stall = !cmd.in_ready;
  assign in_acc = in_valid && cmd.in_ready;
  assign cfg_ready = 1'b1;

  assign opa = pick(cmd.a_sel, px_r, py_r, qx_r, qy_r, ca_r, t0_r, t1_r, t2_r);
  assign opb = pick(cmd.b_sel, px_r, py_r, qx_r, qy_r, ca_r, t0_r, t1_r, t2_r);

  always_comb begin
    stat.in_accept = in_acc;
    stat.alu_done = alu_done;
    stat.m_zero = (modulus_r == '0);
    stat.q_inf = qinf_r;
    stat.t0_zero = (t0_r == '0);
    stat.t1_zero = (t1_r == '0);
    stat.py_zero = (py_r == '0);
    stat.out_free = !out_valid_r || !out_stall;
  end

  ecpa_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cmd.alu),
    .a     (opa),
    .b     (opb),
    .m     (modulus_r),
    .res   (alu_res),
    .done  (alu_done)
  );

  ecpa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .modulus (modulus_r),
    .cmd     (cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '0;
      coeff_a_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MODULUS) modulus_r <= cfg_data;
      else if (cfg_index == REG_COEFF_A) coeff_a_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_p_x;
      py_r <= in_p_y;
      qx_r <= in_q_x;
      qy_r <= in_q_y;
      ca_r <= coeff_a_r;
      qinf_r <= in_q_is_infinity;
    end else if (alu_done) begin
      case (cmd.dst)
        OPND_PX: px_r <= alu_res;
        OPND_PY: py_r <= alu_res;
        OPND_QX: qx_r <= alu_res;
        OPND_QY: qy_r <= alu_res;
        OPND_CA: ca_r <= alu_res;
        OPND_T0: t0_r <= alu_res;
        OPND_T1: t1_r <= alu_res;
        OPND_T2: t2_r <= alu_res;
        default: t0_r <= t0_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      case (cmd.out_kind)
        RES_POINT_P: begin
          rx_r <= px_r;
          ry_r <= py_r;
          rinf_r <= 1'b0;
        end
        RES_SUM: begin
          rx_r <= t1_r;
          ry_r <= t2_r;
          rinf_r <= 1'b0;
        end
        default: begin
          rx_r <= '0;
          ry_r <= '0;
          rinf_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_r_x = rx_r;
  assign out_r_y = ry_r;
  assign out_r_is_infinity = rinf_r;

endmodule

### rtl/core/ecpa_alu.sv
// Shared modular arithmetic unit: registered add and subtract, bit-serial multiply.
module ecpa_alu
  import ecpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  input  word_t    a,
  input  word_t    b,
  input  word_t    m,
  output word_t    res,
  output logic     done
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            a_r, a_nxt;
  word_t            b_r, b_nxt;
  word_t            acc_r, acc_nxt;
  word_t            dbl;

  always_comb begin
    dbl = fadd(acc_r, acc_r, m);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    if (req.start) begin
      case (req.op)
        ALU_ADD: begin
          acc_nxt = fadd(a, b, m);
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          acc_nxt = fsub(a, b, m);
          done_nxt = 1'b1;
        end
        default: begin
          a_nxt = a;
          b_nxt = b;
          acc_nxt = '0;
          cnt_nxt = CNT_W'(FIELD_W - 1);
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      acc_nxt = b_r[FIELD_W-1] ? fadd(dbl, a_r, m) : dbl;
      b_nxt = {b_r[FIELD_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign res = acc_r;
  assign done = done_r;

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("alu started while a multiply runs");
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == '0) |=> (done_r && !busy_r))
    else $error("multiply did not finish after its last step");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done raised while still busy");
`endif

endmodule

### rtl/core/ecpa_ctrl.sv
// Sequencer that drives the shared unit through reduction, inversion and the sum formulas.
module ecpa_ctrl
  import ecpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_stat_t stat,
  input  word_t      modulus,
  output ctrl_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic             launched_r, launched_nxt;
  logic [CNT_W-1:0] bit_r, bit_nxt;
  word_t            expo;

  assign expo = modulus - word_t'(2);

  always_comb begin
    state_nxt = state_r;
    launched_nxt = launched_r;
    bit_nxt = bit_r;
    unique case (state_r)
      S_IDLE: begin
        if (stat.in_accept) state_nxt = stat.m_zero ? S_OUT_INF : S_RPX;
      end
      S_CHK: state_nxt = stat.q_inf ? S_OUT_P : S_XD;
      S_BR: begin
        if (!stat.t0_zero) state_nxt = S_IV1;
        else if (stat.t1_zero && !stat.py_zero) state_nxt = S_SQ;
        else state_nxt = S_OUT_INF;
      end
      S_OUT_P, S_OUT_R, S_OUT_INF: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        if (!launched_r) begin
          launched_nxt = 1'b1;
        end else if (stat.alu_done) begin
          launched_nxt = 1'b0;
          case (state_r)
            S_RPX: state_nxt = S_RPY;
            S_RPY: state_nxt = S_RQX;
            S_RQX: state_nxt = S_RQY;
            S_RQY: state_nxt = S_RA;
            S_RA: state_nxt = S_CHK;
            S_XD: state_nxt = S_YD;
            S_YD: state_nxt = S_BR;
            S_SQ: state_nxt = S_D2;
            S_D2: state_nxt = S_D3;
            S_D3: state_nxt = S_D4;
            S_D4: state_nxt = S_D5;
            S_D5: state_nxt = S_IV1;
            S_IV1: begin
              bit_nxt = CNT_W'(FIELD_W - 1);
              state_nxt = S_IVS;
            end
            S_IVS, S_IVM: begin
              if (state_r == S_IVS && expo[bit_r]) state_nxt = S_IVM;
              else if (bit_r == '0) state_nxt = S_SLP;
              else begin
                bit_nxt = bit_r - CNT_W'(1);
                state_nxt = S_IVS;
              end
            end
            S_SLP: state_nxt = S_X1;
            S_X1: state_nxt = S_X2;
            S_X2: state_nxt = S_X3;
            S_X3: state_nxt = S_Y1;
            S_Y1: state_nxt = S_Y2;
            S_Y2: state_nxt = S_Y3;
            default: state_nxt = S_OUT_R;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    cmd.alu.start = 1'b0;
    cmd.alu.op = ALU_MUL;
    cmd.a_sel = OPND_ONE;
    cmd.b_sel = OPND_ONE;
    cmd.dst = OPND_T0;
    cmd.out_load = 1'b0;
    cmd.out_kind = RES_INF;
    cmd.in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: cmd.in_ready = 1'b1;
      S_CHK, S_BR: cmd.alu.start = 1'b0;
      S_OUT_P: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = RES_POINT_P;
      end
      S_OUT_R: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = RES_SUM;
      end
      S_OUT_INF: begin
        cmd.out_load = stat.out_free;
        cmd.out_kind = RES_INF;
      end
      default: begin
        cmd.alu.start = !launched_r;
        case (state_r)
          S_RPX: begin cmd.b_sel = OPND_PX; cmd.dst = OPND_PX; end
          S_RPY: begin cmd.b_sel = OPND_PY; cmd.dst = OPND_PY; end
          S_RQX: begin cmd.b_sel = OPND_QX; cmd.dst = OPND_QX; end
          S_RQY: begin cmd.b_sel = OPND_QY; cmd.dst = OPND_QY; end
          S_RA: begin cmd.b_sel = OPND_CA; cmd.dst = OPND_CA; end
          S_XD: begin
            cmd.alu.op = ALU_SUB; cmd.a_sel = OPND_QX; cmd.b_sel = OPND_PX; cmd.dst = OPND_T0;
          end
          S_YD: begin
            cmd.alu.op = ALU_SUB; cmd.a_sel = OPND_QY; cmd.b_sel = OPND_PY; cmd.dst = OPND_T1;
          end
          S_SQ: begin cmd.a_sel = OPND_PX; cmd.b_sel = OPND_PX; cmd.dst = OPND_T1; end
          S_D2: begin
            cmd.alu.op = ALU_ADD; cmd.a_sel = OPND_T1; cmd.b_sel = OPND_T1; cmd.dst = OPND_T2;
          end
          S_D3: begin
            cmd.alu.op = ALU_ADD; cmd.a_sel = OPND_T2; cmd.b_sel = OPND_T1; cmd.dst = OPND_T2;
          end
          S_D4: begin
            cmd.alu.op = ALU_ADD; cmd.a_sel = OPND_T2; cmd.b_sel = OPND_CA; cmd.dst = OPND_T1;
          end
          S_D5: begin
            cmd.alu.op = ALU_ADD; cmd.a_sel = OPND_PY; cmd.b_sel = OPND_PY; cmd.dst = OPND_T0;
          end
          S_IV1: cmd.dst = OPND_T2;
          S_IVS: begin cmd.a_sel = OPND_T2; cmd.b_sel = OPND_T2; cmd.dst = OPND_T2; end
          S_IVM: begin cmd.a_sel = OPND_T2; cmd.b_sel = OPND_T0; cmd.dst = OPND_T2; end
          S_SLP: begin cmd.a_sel = OPND_T1; cmd.b_sel = OPND_T2; cmd.dst = OPND_T0; end
          S_X1: begin cmd.a_sel = OPND_T0; cmd.b_sel = OPND_T0; cmd.dst = OPND_T1; end
          S_X2: begin
            cmd.alu.op = ALU_SUB; cmd.a_sel = OPND_T1; cmd.b_sel = OPND_PX; cmd.dst = OPND_T1;
          end
          S_X3: begin
            cmd.alu.op = ALU_SUB; cmd.a_sel = OPND_T1; cmd.b_sel = OPND_QX; cmd.dst = OPND_T1;
          end
          S_Y1: begin
            cmd.alu.op = ALU_SUB; cmd.a_sel = OPND_PX; cmd.b_sel = OPND_T1; cmd.dst = OPND_T2;
          end
          S_Y2: begin cmd.a_sel = OPND_T0; cmd.b_sel = OPND_T2; cmd.dst = OPND_T2; end
          default: begin
            cmd.alu.op = ALU_SUB; cmd.a_sel = OPND_T2; cmd.b_sel = OPND_PY; cmd.dst = OPND_T2;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      launched_r <= launched_nxt;
    end
    bit_r <= bit_nxt;
  end

endmodule

### sim/ec_affine_point_add_test.sv
// Self-checking testbench for the affine point adder, with a built-in sum predictor.
`timescale 1ns / 1ps

module ec_affine_point_add_test;
  import ecpa_pkg::*;

  typedef struct packed {
    word_t x;
    word_t y;
    logic  inf;
  } point_sum_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  word_t                in_p_x;
  word_t                in_p_y;
  word_t                in_q_x;
  word_t                in_q_y;
  logic                 in_q_is_infinity;
  logic                 out_valid;
  logic                 out_stall;
  word_t                out_r_x;
  word_t                out_r_y;
  logic                 out_r_is_infinity;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_data;

  word_t      prime_mod;
  word_t      curve_a;
  point_sum_t sums_due[$];
  int         errors;
  int         burst_left;
  bit         hold_req;
  bit         stall_on;

  ec_affine_point_add uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_p_x(in_p_x), .in_p_y(in_p_y), .in_q_x(in_q_x), .in_q_y(in_q_y),
    .in_q_is_infinity(in_q_is_infinity),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_is_infinity(out_r_is_infinity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("ec_affine_point_add_test: FAIL");
    $finish;
  end

  function automatic word_t mod_mul(word_t x, word_t y, word_t m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return word_t'(prod % {64'd0, m});
  endfunction

  function automatic word_t mod_add(word_t x, word_t y, word_t m);
    logic [64:0] s;
    s = ({1'b0, x} + {1'b0, y}) % {1'b0, m};
    return s[63:0];
  endfunction

  function automatic word_t mod_sub(word_t x, word_t y, word_t m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  function automatic word_t mod_inv(word_t v, word_t m);
    word_t e;
    word_t r;
    e = m - 64'd2;
    r = 64'd1 % m;
    for (int i = 63; i >= 0; i--) begin
      r = mod_mul(r, r, m);
      if (e[i]) r = mod_mul(r, v, m);
    end
    return r;
  endfunction

  function automatic point_sum_t predict_sum(word_t px0, word_t py0, word_t qx0, word_t qy0,
                                             logic qinf);
    point_sum_t r;
    word_t m, px, py, qx, qy, a, xd, yd, s, sq, num;
    r = '{x: '0, y: '0, inf: 1'b1};
    m = prime_mod;
    if (m == 0) return r;
    px = px0 % m;
    py = py0 % m;
    qx = qx0 % m;
    qy = qy0 % m;
    a = curve_a % m;
    if (qinf) return '{x: px, y: py, inf: 1'b0};
    xd = mod_sub(qx, px, m);
    yd = mod_sub(qy, py, m);
    if (xd != 0) begin
      s = mod_mul(yd, mod_inv(xd, m), m);
    end else if (yd == 0 && py != 0) begin
      sq = mod_mul(px, px, m);
      num = mod_add(mod_add(mod_add(sq, sq, m), sq, m), a, m);
      s = mod_mul(num, mod_inv(mod_add(py, py, m), m), m);
    end else begin
      return r;
    end
    r.x = mod_sub(mod_sub(mod_mul(s, s, m), px, m), qx, m);
    r.y = mod_sub(mod_mul(s, mod_sub(px, r.x, m), m), py, m);
    r.inf = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    point_sum_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h inf=%b", $time,
                 out_r_x, out_r_y, out_r_is_infinity);
        errors++;
      end else begin
        want = sums_due.pop_front();
        if (out_r_x !== want.x) begin
          $display("%0t: r_x expected %h actual %h", $time, want.x, out_r_x);
          errors++;
        end
        if (out_r_y !== want.y) begin
          $display("%0t: r_y expected %h actual %h", $time, want.y, out_r_y);
          errors++;
        end
        if (out_r_is_infinity !== want.inf) begin
          $display("%0t: r_is_infinity expected %b actual %b", $time,
                   want.inf, out_r_is_infinity);
          errors++;
        end
      end
    end
  end

  // The receiver stalls in random spells, with quiet stretches and one long hold-off.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (15000) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!stall_on) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 199) == 0) stall_on = ~stall_on;
    end
  end

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_points(word_t px, word_t py, word_t qx, word_t qy, logic qinf);
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_p_x <= px;
    in_p_y <= py;
    in_q_x <= qx;
    in_q_y <= qy;
    in_q_is_infinity <= qinf;
    do @(posedge clk); while (in_stall);
    sums_due.push_back(predict_sum(px, py, qx, qy, qinf));
  endtask

  task automatic drain;
    pause_sender(1);
    while (sums_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MODULUS) prime_mod = value;
    else if (idx == REG_COEFF_A) curve_a = value;
    @(posedge clk);
  endtask

  task automatic set_curve(word_t m, word_t a);
    drain();
    write_reg(REG_MODULUS, m);
    write_reg(REG_COEFF_A, a);
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_zero_modulus;
    send_points(64'd5, 64'd7, 64'd9, 64'd11, 1'b0);
    send_points(64'd5, 64'd7, 64'd9, 64'd11, 1'b1);
  endtask

  task automatic test_small_prime;
    set_curve(64'd97, 64'd2);
    send_points(64'd3, 64'd6, 64'd10, 64'd76, 1'b0);
    send_points(64'd3, 64'd6, 64'd3, 64'd6, 1'b0);
    send_points(64'd3, 64'd6, 64'd3, 64'd91, 1'b0);
    send_points(64'd0, 64'd0, 64'd0, 64'd0, 1'b0);
    send_points(64'd100, 64'd103, 64'd3, 64'd6, 1'b0);
    send_points('1, '1, 64'd1, 64'd2, 1'b1);
    send_points('1, '1, '1, '1, 1'b0);
    send_points(64'd0, 64'd1, 64'd96, 64'd96, 1'b0);
  endtask

  task automatic test_extremes;
    set_curve(64'd18446744073709551557, '1);
    send_points(64'd18446744073709551556, 64'd1, 64'd0, 64'd18446744073709551556, 1'b0);
    send_points('1, '1, '1, '1, 1'b0);
    send_points(64'd12345, 64'd678, 64'd12345, 64'd678, 1'b0);
    send_points(64'd77, 64'd0, 64'd77, 64'd0, 1'b0);
    set_curve(64'd15, 64'd0);
    send_points(64'd2, 64'd4, 64'd7, 64'd1, 1'b0);
    send_points(64'd6, 64'd5, 64'd6, 64'd5, 1'b0);
    set_curve(64'd1, 64'd9);
    send_points(64'd2, 64'd4, 64'd7, 64'd1, 1'b0);
    send_points(64'd2, 64'd4, 64'd7, 64'd1, 1'b1);
  endtask

  task automatic test_random(int count);
    word_t m, px, py, qx, qy;
    logic  qinf;
    int    kind;
    m = prime_mod;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 15);
      px = rand_word();
      py = rand_word();
      if (kind < 12) begin
        px = px % m;
        py = py % m;
      end
      qx = rand_word();
      qy = rand_word();
      if (kind < 10) begin
        qx = qx % m;
        qy = qy % m;
      end
      qinf = (kind == 15);
      if (kind < 4) begin
        qx = px;
        qy = py;
      end else if (kind == 4) begin
        qx = px;
        qy = (py + 64'd1) % m;
      end else if (kind == 5) begin
        py = 64'd0;
        qx = px;
        qy = 64'd0;
      end
      send_points(px, py, qx, qy, qinf);
    end
  endtask

  task automatic test_backpressure;
    hold_req = 1'b1;
    for (int i = 0; i < 3; i++)
      send_points(rand_word() % prime_mod, rand_word() % prime_mod,
                  rand_word() % prime_mod, rand_word() % prime_mod, 1'b0);
    drain();
    send_points(64'd1, 64'd2, 64'd1, 64'd2, 1'b0);
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    hold_req = 1'b0;
    stall_on = 1'b0;
    prime_mod = '0;
    curve_a = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_p_x <= '0;
    in_p_y <= '0;
    in_q_x <= '0;
    in_q_y <= '0;
    in_q_is_infinity <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_modulus();
    test_small_prime();
    test_extremes();
    set_curve(64'd2305843009213693951, 64'd3);
    test_backpressure();
    test_random(24);
    set_curve(64'd18446744073709551557, 64'd18446744073709551550);
    test_random(24);
    set_curve(64'd101, 64'd0);
    test_random(24);
    set_curve(64'd4294967291, '1);
    test_random(24);
    drain();
    if (errors == 0) begin
      $display("ec_affine_point_add_test: PASS");
    end else begin
      $display("ec_affine_point_add_test: FAIL");
    end
    $finish;
  end

endmodule

### ec_affine_point_add.f
rtl/core/ecpa_pkg.sv
rtl/core/ecpa_alu.sv
rtl/core/ecpa_ctrl.sv
rtl/core/ec_affine_point_add.sv
sim/ec_affine_point_add_test.sv
